// ===== src/ange_pkg.sv =====
`default_nettype none

package ange_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int CHANNELS_DEF    = 2;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;
   localparam int STEP_BITS      = 4;

   localparam logic [23:0] UNITY_GAIN = 24'd8388608;
   localparam logic [23:0] W_KEEP     = 24'd16760439;
   localparam logic [23:0] W_NEW      = 24'd16777;
   localparam logic [STEP_BITS-1:0] LAST_STEP = 4'd15;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD = 3'd0,
      CSR_ATTACK    = 3'd1,
      CSR_RELEASE   = 3'd2,
      CSR_SLOPE     = 3'd3,
      CSR_FLOOR     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [22:0] threshold_level;
      logic [23:0] attack_coeff;
      logic [23:0] release_coeff;
      logic [15:0] expansion_slope;
      logic [22:0] range_floor;
   } cfg_type;

   typedef enum logic [3:0] {
      MAC_NONE,
      MAC_ENV_OLD,
      MAC_ENV_NEW,
      MAC_LOG,
      MAC_SLOPE,
      MAC_EXP,
      MAC_SM_OLD,
      MAC_SM_NEW,
      MAC_OUT0,
      MAC_OUT1
   } mac_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic                 in_ready;
      mac_sel_type          mac_sel;
      acc_op_type           acc_op;
      logic [STEP_BITS-1:0] step;
      logic                 env_wr;
      logic                 log_init;
      logic                 log_src_thr;
      logic                 log_step;
      logic                 le_save;
      logic                 exp_init;
      logic                 exp_step;
      logic                 tgt_unity;
      logic                 tgt_wr;
      logic                 gain_wr;
      logic                 y0_wr;
      logic                 out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic below;
      logic out_full;
   } dp_status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ENV0,
      S_ENV1,
      S_ENVW,
      S_CHK,
      S_LOGE,
      S_LOGT0,
      S_LOGT,
      S_SLOPE,
      S_EXP0,
      S_EXP,
      S_TGT,
      S_SM0,
      S_SM1,
      S_SMW,
      S_OUT0,
      S_OUT1,
      S_OUT2
   } state_type;

endpackage

`default_nettype wire

// ===== src/ange_if.sv =====
`default_nettype none

interface ange_req_if import ange_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_ch0;
   logic signed [SAMPLE_BITS-1:0] sample_ch1;
   modport source (output valid, sample_ch0, sample_ch1, input ready);
   modport sink   (input valid, sample_ch0, sample_ch1, output ready);
endinterface

interface ange_rsp_if import ange_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] gated_ch0;
   logic signed [SAMPLE_BITS-1:0] gated_ch1;
   logic [23:0]                   applied_gain;
   modport source (output valid, gated_ch0, gated_ch1, applied_gain, input ready);
   modport sink   (input valid, gated_ch0, gated_ch1, applied_gain, output ready);
endinterface

interface ange_csr_if import ange_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] wr_index;
   logic [CSR_DATA_BITS-1:0]  wr_data;
   modport source (output valid, wr_index, wr_data, input ready);
   modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

`default_nettype wire

// ===== src/ange_csr.sv =====
`default_nettype none

module ange_csr import ange_pkg::*; (
   input  wire     clock,
   input  wire     reset,
   ange_csr_if.sink csr_bus,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.wr_index))
            CSR_THRESHOLD: cfg_in.threshold_level = csr_bus.wr_data[22:0];
            CSR_ATTACK:    cfg_in.attack_coeff    = csr_bus.wr_data[23:0];
            CSR_RELEASE:   cfg_in.release_coeff   = csr_bus.wr_data[23:0];
            CSR_SLOPE:     cfg_in.expansion_slope = csr_bus.wr_data[15:0];
            CSR_FLOOR:     cfg_in.range_floor     = csr_bus.wr_data[22:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_level <= 23'd83886;
         cfg_ff.attack_coeff    <= 24'd16431300;
         cfg_ff.release_coeff   <= 24'd16773721;
         cfg_ff.expansion_slope <= 16'd58982;
         cfg_ff.range_floor     <= 23'd839;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/ange_ctrl.sv =====
`default_nettype none

module ange_ctrl import ange_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cmd         = '0;
      cmd.mac_sel = MAC_NONE;
      cmd.acc_op  = ACC_HOLD;
      cmd.step    = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.in_ready = 1'b1;
            if (status.req_valid) state_in = S_ENV0;
         end
         S_ENV0: begin
            cmd.mac_sel = MAC_ENV_OLD;
            cmd.acc_op  = ACC_LOAD;
            state_in    = S_ENV1;
         end
         S_ENV1: begin
            cmd.mac_sel = MAC_ENV_NEW;
            cmd.acc_op  = ACC_ADD;
            state_in    = S_ENVW;
         end
         S_ENVW: begin
            cmd.env_wr = 1'b1;
            state_in   = S_CHK;
         end
         S_CHK: begin
            if (status.below) begin
               cmd.log_init = 1'b1;
               cnt_in       = '0;
               state_in     = S_LOGE;
            end else begin
               cmd.tgt_unity = 1'b1;
               state_in      = S_SM0;
            end
         end
         S_LOGE: begin
            cmd.mac_sel  = MAC_LOG;
            cmd.log_step = 1'b1;
            cnt_in       = cnt_ff + 4'd1;
            if (cnt_ff == LAST_STEP) state_in = S_LOGT0;
         end
         S_LOGT0: begin
            cmd.le_save     = 1'b1;
            cmd.log_init    = 1'b1;
            cmd.log_src_thr = 1'b1;
            cnt_in          = '0;
            state_in        = S_LOGT;
         end
         S_LOGT: begin
            cmd.mac_sel  = MAC_LOG;
            cmd.log_step = 1'b1;
            cnt_in       = cnt_ff + 4'd1;
            if (cnt_ff == LAST_STEP) state_in = S_SLOPE;
         end
         S_SLOPE: begin
            cmd.mac_sel = MAC_SLOPE;
            cmd.acc_op  = ACC_LOAD;
            state_in    = S_EXP0;
         end
         S_EXP0: begin
            cmd.exp_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_EXP;
         end
         S_EXP: begin
            cmd.mac_sel  = MAC_EXP;
            cmd.exp_step = 1'b1;
            cnt_in       = cnt_ff + 4'd1;
            if (cnt_ff == LAST_STEP) state_in = S_TGT;
         end
         S_TGT: begin
            cmd.tgt_wr = 1'b1;
            state_in   = S_SM0;
         end
         S_SM0: begin
            cmd.mac_sel = MAC_SM_OLD;
            cmd.acc_op  = ACC_LOAD;
            state_in    = S_SM1;
         end
         S_SM1: begin
            cmd.mac_sel = MAC_SM_NEW;
            cmd.acc_op  = ACC_ADD;
            state_in    = S_SMW;
         end
         S_SMW: begin
            cmd.gain_wr = 1'b1;
            state_in    = S_OUT0;
         end
         S_OUT0: begin
            cmd.mac_sel = MAC_OUT0;
            cmd.acc_op  = ACC_LOAD;
            state_in    = S_OUT1;
         end
         S_OUT1: begin
            cmd.y0_wr   = 1'b1;
            cmd.mac_sel = MAC_OUT1;
            cmd.acc_op  = ACC_LOAD;
            state_in    = S_OUT2;
         end
         S_OUT2: begin
            if (!status.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && status.req_valid) |=> state_ff == S_ENV0)
      else $error("accepted item did not start envelope update");

   a_log_handover: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOGE && cnt_ff == LAST_STEP) |=> (state_ff == S_LOGT0 && cnt_ff == LAST_STEP + 4'd1))
      else $error("envelope log did not hand over to threshold log");

endmodule

`default_nettype wire

// ===== src/ange_dp.sv =====
`default_nettype none

module ange_dp import ange_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int CHANNELS    = CHANNELS_DEF
) (
   input  wire            clock,
   input  wire            reset,
   ange_req_if.sink       req_bus,
   ange_rsp_if.source     rsp_bus,
   input  cfg_type        cfg,
   input  dp_cmd_type     cmd,
   output dp_status_type  status
);

   localparam int DOWN = (SAMPLE_BITS > 24) ? SAMPLE_BITS - 24 : 0;
   localparam int UP   = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;
   localparam int MW   = SAMPLE_BITS + UP;
   localparam logic signed [42:0] Y_HI = (43'sd1 <<< (SAMPLE_BITS - 1)) - 43'sd1;
   localparam logic signed [42:0] Y_LO = -(43'sd1 <<< (SAMPLE_BITS - 1));

   typedef logic [15:0][30:0] root_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v, r, b;
      v = v_in;
      r = '0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > v) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // 2^(-2^-k), k = 1..16, Q1.30 by floor square roots from one half
   function automatic root_tab_type build_roots();
      root_tab_type t;
      logic [63:0]  root;
      root = 64'd1 << 29;
      for (int k = 0; k < 16; k++) begin
         root = isqrt64(root << 30);
         t[k] = root[30:0];
      end
      return t;
   endfunction

   localparam root_tab_type ROOTS = build_roots();

   function automatic logic [23:0] mag_q23(input logic signed [SAMPLE_BITS-1:0] v);
      logic [SAMPLE_BITS-1:0] m;
      logic [MW-1:0]          t;
      m = v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
      t = (MW'(m) << UP) >> DOWN;
      return t[23:0];
   endfunction

   function automatic logic [4:0] top_bit(input logic [23:0] v);
      logic [4:0] r;
      r = '0;
      for (int i = 0; i < 24; i++) begin
         if (v[i]) r = 5'(i);
      end
      return r;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] sat_y(input logic signed [42:0] v);
      logic signed [42:0] c;
      c = v;
      if (v > Y_HI) c = Y_HI;
      if (v < Y_LO) c = Y_LO;
      return c[SAMPLE_BITS-1:0];
   endfunction

   logic signed [SAMPLE_BITS-1:0] x0_ff, x1_ff, y0_ff;
   logic signed [SAMPLE_BITS-1:0] x1_take;
   logic [23:0]  peak_ff, env_ff, gain_ff, target_ff;
   logic signed [65:0] acc_ff, acc_in, prod;
   logic signed [32:0] mul_a, mul_b;
   logic [30:0]  m_ff, g_ff;
   logic [4:0]   e_ff;
   logic [15:0]  frac_ff;
   logic [20:0]  le_ff, r_ff, lt, d;
   logic [23:0]  c_sel, p0, p1;
   logic [24:0]  c_rest;
   logic         take;
   logic [23:0]  log_x, log_nz;
   logic [4:0]   log_e;
   logic [30:0]  log_m;
   logic [31:0]  sq;
   logic [5:0]   sh;
   logic [30:0]  g_sh;
   logic [23:0]  tgt_val, floor_ext;
   logic signed [65:0] acc_r23, acc_r22;
   logic         rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_ch0_ff, rsp_ch1_ff;
   logic [23:0]  rsp_gain_ff;

   assign take          = req_bus.valid && cmd.in_ready;
   assign req_bus.ready = cmd.in_ready;
   assign x1_take       = (CHANNELS > 1) ? req_bus.sample_ch1 : '0;
   assign p0            = mag_q23(req_bus.sample_ch0);
   assign p1            = mag_q23(x1_take);

   assign c_sel  = (peak_ff > env_ff) ? cfg.attack_coeff : cfg.release_coeff;
   assign c_rest = (25'd1 << 24) - {1'b0, c_sel};
   assign lt     = {e_ff, frac_ff};
   assign d      = (lt > le_ff) ? lt - le_ff : '0;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mac_sel)
         MAC_ENV_OLD: begin mul_a = {9'b0, c_sel};      mul_b = {9'b0, env_ff};  end
         MAC_ENV_NEW: begin mul_a = {8'b0, c_rest};     mul_b = {9'b0, peak_ff}; end
         MAC_LOG:     begin mul_a = {2'b0, m_ff};       mul_b = {2'b0, m_ff};    end
         MAC_SLOPE:   begin mul_a = {12'b0, d};
                            mul_b = {17'b0, cfg.expansion_slope};               end
         MAC_EXP:     begin mul_a = {2'b0, g_ff};
                            mul_b = {2'b0, ROOTS[cmd.step]};                    end
         MAC_SM_OLD:  begin mul_a = {9'b0, W_KEEP};     mul_b = {9'b0, gain_ff}; end
         MAC_SM_NEW:  begin mul_a = {9'b0, W_NEW};      mul_b = {9'b0, target_ff}; end
         MAC_OUT0:    begin mul_a = 33'(x0_ff);         mul_b = {9'b0, gain_ff}; end
         MAC_OUT1:    begin mul_a = 33'(x1_ff);         mul_b = {9'b0, gain_ff}; end
         default:     begin mul_a = '0;                 mul_b = '0;              end
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD: acc_in = prod;
         ACC_ADD:  acc_in = acc_ff + prod;
         default:  acc_in = acc_ff;
      endcase
   end

   assign acc_r23 = acc_ff + (66'sd1 <<< 23);
   assign acc_r22 = acc_ff + (66'sd1 <<< 22);

   // log2 normalisation: zero taken as one LSB
   assign log_x  = cmd.log_src_thr ? {1'b0, cfg.threshold_level} : env_ff;
   assign log_nz = (log_x == 24'd0) ? 24'd1 : log_x;
   assign log_e  = top_bit(log_nz);
   assign log_m  = 31'(log_nz) << (5'd30 - log_e);
   assign sq     = prod[61:30];

   assign sh        = {1'b0, r_ff[20:16]} + 6'd7;
   assign g_sh      = g_ff >> sh;
   assign floor_ext = {1'b0, cfg.range_floor};
   assign tgt_val   = (g_sh[23:0] < floor_ext) ? floor_ext : g_sh[23:0];

   always_ff @(posedge clock) begin
      if (take) begin
         x0_ff   <= req_bus.sample_ch0;
         x1_ff   <= x1_take;
         peak_ff <= (p1 > p0) ? p1 : p0;
      end
      acc_ff <= acc_in;
      if (cmd.log_init) begin
         e_ff    <= log_e;
         m_ff    <= log_m;
         frac_ff <= '0;
      end else if (cmd.log_step) begin
         m_ff    <= sq[31] ? sq[31:1] : sq[30:0];
         frac_ff <= {frac_ff[14:0], sq[31]};
      end
      if (cmd.le_save) le_ff <= lt;
      if (cmd.exp_init) begin
         r_ff <= acc_ff[36:16];
         g_ff <= 31'd1 << 30;
      end else if (cmd.exp_step && r_ff[4'd15 - cmd.step]) begin
         g_ff <= prod[60:30];
      end
      if (cmd.tgt_unity) target_ff <= UNITY_GAIN;
      else if (cmd.tgt_wr) target_ff <= tgt_val;
      if (cmd.y0_wr) y0_ff <= sat_y(acc_r22[65:23]);
      if (cmd.out_load) begin
         rsp_ch0_ff  <= y0_ff;
         rsp_ch1_ff  <= (CHANNELS > 1) ? sat_y(acc_r22[65:23]) : '0;
         rsp_gain_ff <= gain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff       <= '0;
         gain_ff      <= UNITY_GAIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.env_wr)  env_ff  <= acc_r23[47:24];
         if (cmd.gain_wr) gain_ff <= acc_r23[47:24];
         if (cmd.out_load)       rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.gated_ch0    = rsp_ch0_ff;
   assign rsp_bus.gated_ch1    = rsp_ch1_ff;
   assign rsp_bus.applied_gain = rsp_gain_ff;

   assign status.req_valid = req_bus.valid;
   assign status.below     = env_ff < {1'b0, cfg.threshold_level};
   assign status.out_full  = rsp_valid_ff && !rsp_bus.ready;

   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_gain_ff <= UNITY_GAIN)
      else $error("applied gain above unity");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp_bus.ready))
      else $error("result register overwritten while held");

   a_env_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.env_wr |=> env_ff <= UNITY_GAIN)
      else $error("envelope above full scale");

endmodule

`default_nettype wire

// ===== src/audio_noise_gate_expander.sv =====
// Channel   Dir  Handshake      Payload
// req_bus   in   valid/ready    sample_ch0, sample_ch1 (signed, SAMPLE_BITS)
// rsp_bus   out  valid/ready    gated_ch0, gated_ch1 (signed), applied_gain (Q1.23)
// csr_bus   in   valid/ready    wr_index (3b), wr_data (24b); ready always high
//
// At or above threshold the log2/exp2 steps are skipped; below it,
// the two 16-step log2 squarings and the 16-step exp2 product share one MAC.
// Synchronous active-high reset; envelope clears, smoothed gain goes to unity.
// A held result does not block intake; the last step waits only while the
// output register is still full.
`default_nettype none

module audio_noise_gate_expander import ange_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int CHANNELS    = CHANNELS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   ange_req_if.sink   req_bus,
   ange_rsp_if.source rsp_bus,
   ange_csr_if.sink   csr_bus
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // register file; the user writes it only between items, the block itself does not enforce it
   ange_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // sequencer: envelope, log2 pair, slope, exp2 (below threshold only), smoothing, output
   ange_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // shared MAC, log/exp registers, state and output register
   ange_dp #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CHANNELS    (CHANNELS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cfg     (cfg),
      .cmd     (cmd),
      .status  (status)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_audio_noise_gate_expander.sv =====
`timescale 1ns / 1ps

module tb_audio_noise_gate_expander;
   import ange_pkg::*;

   typedef struct packed {
      logic signed [23:0] ch0;
      logic signed [23:0] ch1;
   } frame_type;

   typedef struct packed {
      logic [23:0] out0;
      logic [23:0] out1;
      logic [23:0] gain;
   } gated_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ange_req_if req_bus ();
   ange_rsp_if rsp_bus ();
   ange_csr_if csr_bus ();

   audio_noise_gate_expander u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state and register shadow
   logic [23:0] env_q, gain_q;
   logic [22:0] thr_q, floor_q;
   logic [23:0] atk_q, rel_q;
   logic [15:0] slope_q;

   frame_type frames_pending[$];
   gated_type gated_expected[$];
   int        fail_count = 0;

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] r, b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Q8.16 log2 by repeated squaring of a Q1.30 mantissa
   function automatic logic [63:0] log2_fix(input logic [23:0] x);
      logic [63:0] m, frac;
      int e;
      frac = '0;
      e = 0;
      if (x == 0) x = 24'd1;
      while (e < 23 && (x >> (e + 1)) != 0) e++;
      m = 64'(x) << (30 - e);
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            frac = frac | 64'd1;
            m = m >> 1;
         end
      end
      return (64'(e) << 16) | frac;
   endfunction

   function automatic logic [63:0] exp2_down(input logic [63:0] r);
      logic [63:0] n, f, root, g, sh;
      n = r >> 16;
      f = r & 64'hFFFF;
      root = 64'd1 << 29;
      g = 64'd1 << 30;
      for (int k = 1; k <= 16; k++) begin
         root = floor_sqrt(root << 30);
         if (((f >> (16 - k)) & 64'd1) != 0) g = (g * root) >> 30;
      end
      sh = 64'd7 + n;
      if (sh >= 32) return 64'd0;
      return g >> sh;
   endfunction

   function automatic logic [23:0] scale_sat(input logic signed [23:0] x,
                                             input logic [23:0] g);
      longint p, y;
      p = longint'(x) * longint'({40'd0, g}) + (64'sd1 << 22);
      y = p >>> 23;
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      return y[23:0];
   endfunction

   function automatic gated_type gate_frame(input frame_type f);
      logic [63:0] a0, a1, pk, c, e, tgt, le, lt, d, g;
      gated_type r;
      a0 = f.ch0 < 0 ? 64'(-longint'(f.ch0)) : 64'(f.ch0);
      a1 = f.ch1 < 0 ? 64'(-longint'(f.ch1)) : 64'(f.ch1);
      pk = a1 > a0 ? a1 : a0;
      e = 64'(env_q);
      c = pk > e ? 64'(atk_q) : 64'(rel_q);
      e = (c * e + ((64'd1 << 24) - c) * pk + (64'd1 << 23)) >> 24;
      env_q = e[23:0];
      tgt = 64'd1 << 23;
      if (env_q < {1'b0, thr_q}) begin
         le = log2_fix(env_q);
         lt = log2_fix({1'b0, thr_q});
         d = lt > le ? lt - le : 64'd0;
         tgt = exp2_down((d * 64'(slope_q)) >> 16);
         if (tgt < 64'(floor_q)) tgt = 64'(floor_q);
      end
      g = (64'(W_KEEP) * 64'(gain_q) + 64'(W_NEW) * tgt + (64'd1 << 23)) >> 24;
      gain_q = g[23:0];
      r.out0 = scale_sat(f.ch0, gain_q);
      r.out1 = scale_sat(f.ch1, gain_q);
      r.gain = gain_q;
      return r;
   endfunction

   // driver: one item at a time, random gap before each
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_bus.ready) begin
      end else begin
         if (req_bus.valid) begin
            gated_expected.push_back(gate_frame(frames_pending.pop_front()));
            req_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
         end
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (frames_pending.size() > 0) begin
            req_bus.valid      <= 1'b1;
            req_bus.sample_ch0 <= frames_pending[0].ch0;
            req_bus.sample_ch1 <= frames_pending[0].ch1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor: random back-pressure, compare against oldest expectation
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (gated_expected.size() == 0) begin
               $error("unexpected item: gated_ch0 %0d", rsp_bus.gated_ch0);
               fail_count++;
            end else begin
               gated_type w;
               w = gated_expected.pop_front();
               if (rsp_bus.gated_ch0 !== w.out0) begin
                  $error("gated_ch0 exp %0d got %0d", $signed(w.out0), rsp_bus.gated_ch0);
                  fail_count++;
               end
               if (rsp_bus.gated_ch1 !== w.out1) begin
                  $error("gated_ch1 exp %0d got %0d", $signed(w.out1), rsp_bus.gated_ch1);
                  fail_count++;
               end
               if (rsp_bus.applied_gain !== w.gain) begin
                  $error("applied_gain exp %0d got %0d", w.gain, rsp_bus.applied_gain);
                  fail_count++;
               end
            end
            rsp_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // an idle gap after each write keeps back-to-back calls apart
   task automatic csr_write(input csr_index_type idx, input logic [23:0] val);
      csr_bus.valid    <= 1'b1;
      csr_bus.wr_index <= idx;
      csr_bus.wr_data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_THRESHOLD: thr_q   = val[22:0];
         CSR_ATTACK:    atk_q   = val;
         CSR_RELEASE:   rel_q   = val;
         CSR_SLOPE:     slope_q = val[15:0];
         CSR_FLOOR:     floor_q = val[22:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      while (frames_pending.size() > 0 || gated_expected.size() > 0 || req_bus.valid)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic signed [23:0] rand_sample(input int lvl);
      logic signed [23:0] s;
      s = 24'($urandom);
      case (lvl)
         0: s = s >>> 17;          // well below the reset threshold
         1: s = s >>> 8;
         default: ;
      endcase
      return s;
   endfunction

   // bursts of loud and quiet frames so the gate opens and closes
   task automatic queue_program(input int n);
      int lvl;
      frame_type f;
      lvl = 0;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 40) == 0) lvl = $urandom_range(0, 2);
         f.ch0 = rand_sample(lvl);
         f.ch1 = $urandom_range(0, 7) == 0 ? 24'sd0 : rand_sample(lvl);
         frames_pending.push_back(f);
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.sample_ch0 = '0;
      req_bus.sample_ch1 = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.wr_index = CSR_THRESHOLD;
      csr_bus.wr_data = '0;
      thr_q = 23'd83886;
      atk_q = 24'd16431300;
      rel_q = 24'd16773721;
      slope_q = 16'd58982;
      floor_q = 23'd839;
      env_q = '0;
      gain_q = UNITY_GAIN;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes at reset settings, silence, mono-style frames
      frames_pending.push_back('{24'sh7FFFFF, 24'sh800000});
      frames_pending.push_back('{24'sh800000, 24'sh7FFFFF});
      frames_pending.push_back('{24'sh000001, -24'sd1});
      for (int i = 0; i < 12; i++) frames_pending.push_back('{24'sd0, 24'sd0});
      frames_pending.push_back('{24'sh555555, 24'shAAAAAA});
      frames_pending.push_back('{24'shAAAAAA, 24'sd0});
      drain();

      // hard gate: instant envelope, strong reduction, deep floor
      csr_write(CSR_ATTACK, 24'd0);
      csr_write(CSR_RELEASE, 24'd0);
      csr_write(CSR_SLOPE, 24'h00FFFF);
      csr_write(CSR_FLOOR, 24'd0);
      csr_write(CSR_THRESHOLD, 24'h7FFFFF);
      frames_pending.push_back('{24'sd0, 24'sd0});
      frames_pending.push_back('{24'sh7FFFFF, 24'sd0});
      queue_program(350);
      drain();

      // gate disabled by zero threshold, slow coefficients, floor at top
      csr_write(CSR_THRESHOLD, 24'd0);
      csr_write(CSR_ATTACK, 24'hFFFFFF);
      csr_write(CSR_RELEASE, 24'hFFFFFF);
      csr_write(CSR_FLOOR, 24'h7FFFFF);
      queue_program(300);
      drain();

      // zero slope, random threshold
      csr_write(CSR_SLOPE, 24'd0);
      csr_write(CSR_THRESHOLD, {1'b0, 23'($urandom)});
      queue_program(200);
      drain();

      // random mid settings
      for (int p = 0; p < 4; p++) begin
         csr_write(CSR_THRESHOLD, {1'b0, 23'($urandom) >> $urandom_range(0, 12)});
         csr_write(CSR_ATTACK, 24'($urandom_range(0, 24'hFFFFFF)));
         csr_write(CSR_RELEASE, 24'hFFFFFF - 24'($urandom_range(0, 24'h0FFFFF)));
         csr_write(CSR_SLOPE, {8'd0, 16'($urandom)});
         csr_write(CSR_FLOOR, {1'b0, 23'($urandom) >> $urandom_range(4, 23)});
         queue_program(140);
         drain();
      end
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/ange_pkg.sv
src/ange_if.sv
src/ange_csr.sv
src/ange_ctrl.sv
src/ange_dp.sv
src/audio_noise_gate_expander.sv
tb/sv/tb_audio_noise_gate_expander.sv
